// ===== rtl/udpck_pkg.sv =====
// Shared types, constants and one's complement helpers for the UDP checksum unit.
// Depends on nothing; every other file in rtl imports it.
`timescale 1ns / 1ps

package udpck_pkg;

   // Lane count limits and default.
   localparam int MAX_BYTES_PER_ITEM     = 8;
   localparam int DEFAULT_BYTES_PER_ITEM = 8;

   // Field widths fixed by the interface.
   localparam int PAYLOAD_W     = 64;
   localparam int COUNT_W       = 4;
   localparam int WORD16_W      = 16;
   localparam int TOTAL_W       = 17;
   localparam int HDR_SUM_W     = 21;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 64;

   // Byte counter saturates here; payloads above the limit overflow the length field.
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX        = 17'h1FFFF;
   localparam logic [TOTAL_W-1:0]  PAYLOAD_LIMIT    = 17'd65527;
   localparam logic [15:0]         UDP_HEADER_BYTES = 16'd8;
   localparam logic [15:0]         LENGTH_SATURATED = 16'hFFFF;
   localparam logic [7:0]          UDP_PROTOCOL     = 8'd17;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IP_VERSION_SIX      = 3'd0,
      CSR_SOURCE_ADDRESS_HIGH = 3'd1,
      CSR_SOURCE_ADDRESS_LOW  = 3'd2,
      CSR_DEST_ADDRESS_HIGH   = 3'd3,
      CSR_DEST_ADDRESS_LOW    = 3'd4,
      CSR_SOURCE_PORT         = 3'd5,
      CSR_DEST_PORT           = 3'd6,
      CSR_PROTOCOL_NUMBER     = 3'd7
   } csr_index_type;

   // Input and result words.
   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload_bytes;
      logic [COUNT_W-1:0]   valid_bytes;
      logic                 last_item;
   } req_word_type;

   typedef struct packed {
      logic [15:0] checksum_value;
      logic [15:0] datagram_length;
      logic        length_overflow;
   } rsp_word_type;

   // Control from the lane stage into the merge stage.
   typedef struct packed {
      logic move;
      logic last;
   } merge_ctrl_type;

   // A closed datagram waiting for the pseudo header.
   typedef struct packed {
      logic        valid;
      logic [15:0] sum;
      logic [15:0] len;
      logic        over;
   } stage_two_type;

   // First end-around fold of a wide sum; the result stays below 0x1FFFF.
   function automatic logic [16:0] ones_fold_wide(input logic [31:0] s);
      ones_fold_wide = {1'b0, s[15:0]} + {1'b0, s[31:16]};
   endfunction

   // Second fold; the carry cannot ripple out because the input is at most 0x1FFFE.
   function automatic logic [15:0] ones_fold_narrow(input logic [16:0] s);
      logic [16:0] t;
      t = {1'b0, s[15:0]} + {16'h0, s[16]};
      ones_fold_narrow = t[15:0];
   endfunction

   // Sum of the four 16-bit words of a 64-bit value.
   function automatic logic [17:0] words_of_64(input logic [63:0] v);
      words_of_64 = {2'b00, v[15:0]} + {2'b00, v[31:16]}
                  + {2'b00, v[47:32]} + {2'b00, v[63:48]};
   endfunction

endpackage

// ===== rtl/udp_pseudo_header_checksum_unit.sv =====
// UDP checksum unit top level: byte lanes, merge stage, pseudo header and result register.
// Depends on udpck_pkg, udpck_lane, udpck_merge and udpck_pseudo_hdr.
`timescale 1ns / 1ps

// Computes the UDP checksum of a datagram streamed as words of BYTES_PER_ITEM
// payload bytes, one word per cycle while req_stall is low, with no gaps
// required between words or datagrams. A word is registered into the byte
// lanes on acceptance, then summed into the running one's complement sum by
// the merge adder; on a last word the closed sum is registered in the merge
// stage, the pseudo header and length are added to it and the result is
// registered in the result register that drives rsp_valid. The byte counter
// and lane parity update every cycle, so throughput is one word per clock
// while req_stall is low; while a result waits on rsp_stall the merge stage
// holds one more closed datagram, and req_stall is raised only once the last
// word of a further datagram reaches the lanes. The pseudo header sum is
// registered in the cycle after a configuration write; the csr port is always ready.
module udp_pseudo_header_checksum_unit #(
   parameter int BYTES_PER_ITEM = udpck_pkg::DEFAULT_BYTES_PER_ITEM
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  udpck_pkg::req_word_type           req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output udpck_pkg::rsp_word_type           rsp_word,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [udpck_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [udpck_pkg::CSR_DATA_W-1:0]  csr_data
);
   import udpck_pkg::*;

   localparam logic [COUNT_W-1:0] LANE_COUNT = COUNT_W'(BYTES_PER_ITEM);
   localparam int                 FINISH_W   = HDR_SUM_W + 1;

   logic                 accept;
   logic [COUNT_W-1:0]   byte_count;
   logic [TOTAL_W:0]     total_sum;
   logic [TOTAL_W-1:0]   new_total;
   logic                 new_over;
   logic [15:0]          new_len;
   logic [TOTAL_W-1:0]   byte_total_ff;
   logic [TOTAL_W-1:0]   byte_total_in;

   logic [BYTES_PER_ITEM-1:0][15:0] lane_word;
   logic [BYTES_PER_ITEM-1:0][15:0] lane_word_ff;
   logic                 lane_valid_ff;
   logic                 lane_valid_in;
   logic                 lane_last_ff;
   logic [15:0]          lane_len_ff;
   logic                 lane_over_ff;

   merge_ctrl_type       merge_ctrl;
   logic                 merge_advance;
   stage_two_type        stage_two;
   logic [HDR_SUM_W-1:0] hdr_sum;

   logic                 out_take;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_word_type         rsp_word_ff;
   logic [FINISH_W-1:0]  finish_sum;
   logic [15:0]          finish_fold;

   // Handshakes.
   assign merge_ctrl.move = lane_valid_ff && (!lane_last_ff || merge_advance);
   assign merge_ctrl.last = lane_last_ff;
   assign req_stall       = lane_valid_ff && !merge_ctrl.move;
   assign accept          = req_valid && !req_stall;
   assign csr_ready       = 1'b1;

   // Byte count of this word and the saturating datagram length.
   always_comb begin
      byte_count = (req_word.valid_bytes > LANE_COUNT) ? LANE_COUNT : req_word.valid_bytes;
      total_sum  = {1'b0, byte_total_ff} + (TOTAL_W + 1)'(byte_count);
      new_total  = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
      new_over   = new_total > PAYLOAD_LIMIT;
      new_len    = new_over ? LENGTH_SATURATED : (new_total[15:0] + UDP_HEADER_BYTES);
      if (!accept) begin
         byte_total_in = byte_total_ff;
      end else if (req_word.last_item) begin
         byte_total_in = '0;
      end else begin
         byte_total_in = new_total;
      end
   end

   // Byte lanes; a saturated count freezes the parity at odd.
   for (genvar k = 0; k < BYTES_PER_ITEM; k++) begin : g_lane
      logic [TOTAL_W:0] position;
      logic             odd;

      assign position = {1'b0, byte_total_ff} + (TOTAL_W + 1)'(k);
      assign odd      = (position >= {1'b0, TOTAL_MAX}) || position[0];

      udpck_lane u_lane (
         .lane_byte (req_word.payload_bytes[PAYLOAD_W-1-8*k -: 8]),
         .lane_used (COUNT_W'(k) < byte_count),
         .lane_odd  (odd),
         .lane_word (lane_word[k])
      );
   end

   // Lane stage registers.
   assign lane_valid_in = accept || (lane_valid_ff && !merge_ctrl.move);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_total_ff <= '0;
         lane_valid_ff <= 1'b0;
      end else begin
         byte_total_ff <= byte_total_in;
         lane_valid_ff <= lane_valid_in;
      end
      if (accept) begin
         lane_word_ff <= lane_word;
         lane_last_ff <= req_word.last_item;
         lane_len_ff  <= new_len;
         lane_over_ff <= new_over;
      end
   end

   udpck_merge #(
      .BYTES_PER_ITEM (BYTES_PER_ITEM)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .lane_words (lane_word_ff),
      .ctrl       (merge_ctrl),
      .item_len   (lane_len_ff),
      .item_over  (lane_over_ff),
      .out_take   (out_take),
      .advance    (merge_advance),
      .stage_two  (stage_two)
   );

   udpck_pseudo_hdr u_pseudo_hdr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .hdr_sum   (hdr_sum)
   );

   // Finish: add the pseudo header and the length twice, fold and invert.
   always_comb begin
      finish_sum  = FINISH_W'(stage_two.sum) + FINISH_W'(hdr_sum)
                  + FINISH_W'({stage_two.len, 1'b0});
      finish_fold = ones_fold_narrow(ones_fold_wide(32'(finish_sum)));
   end

   // Result register.
   assign out_take     = stage_two.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = out_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_take) begin
         rsp_word_ff.checksum_value  <= ~finish_fold;
         rsp_word_ff.datagram_length <= stage_two.len;
         rsp_word_ff.length_overflow <= stage_two.over;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTH
   // A last word always restarts the byte count.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_word.last_item |=> byte_total_ff == '0)
      else $error("byte count not cleared after last word");

   // Input only backs up behind a closed datagram.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> lane_valid_ff && lane_last_ff && stage_two.valid)
      else $error("input stalled without a pending datagram");

   // An overflowed length is always reported saturated.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.length_overflow |-> rsp_word.datagram_length == LENGTH_SATURATED)
      else $error("overflow reported with unsaturated length");
`endif

endmodule

// ===== rtl/udpck_lane.sv =====
// One byte lane: places a payload byte in the high or low half of a 16-bit word.
// Depends on udpck_pkg.
`timescale 1ns / 1ps

module udpck_lane (
   input  logic [7:0]  lane_byte,
   input  logic        lane_used,
   input  logic        lane_odd,
   output logic [15:0] lane_word
);
   import udpck_pkg::*;

   // Even datagram positions land in the high half, odd ones in the low half.
   always_comb begin
      if (!lane_used) begin
         lane_word = '0;
      end else if (lane_odd) begin
         lane_word = {8'h00, lane_byte};
      end else begin
         lane_word = {lane_byte, 8'h00};
      end
   end

endmodule

// ===== rtl/udpck_pseudo_hdr.sv =====
// Configuration registers and the registered pseudo header sum built from them.
// Depends on udpck_pkg.
`timescale 1ns / 1ps

module udpck_pseudo_hdr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [udpck_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [udpck_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic [udpck_pkg::HDR_SUM_W-1:0]    hdr_sum
);
   import udpck_pkg::*;

   logic        ip_version_six_ff;
   logic [63:0] source_address_high_ff;
   logic [63:0] source_address_low_ff;
   logic [63:0] dest_address_high_ff;
   logic [63:0] dest_address_low_ff;
   logic [15:0] source_port_ff;
   logic [15:0] dest_port_ff;
   logic [7:0]  protocol_number_ff;

   logic [HDR_SUM_W-1:0] hdr_sum_ff;
   logic [HDR_SUM_W-1:0] hdr_sum_in;
   logic [63:0]          src_high_used;
   logic [63:0]          src_low_used;
   logic [63:0]          dst_high_used;
   logic [63:0]          dst_low_used;
   logic [7:0]           protocol_used;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ip_version_six_ff      <= 1'b0;
         source_address_high_ff <= '0;
         source_address_low_ff  <= '0;
         dest_address_high_ff   <= '0;
         dest_address_low_ff    <= '0;
         source_port_ff         <= '0;
         dest_port_ff           <= '0;
         protocol_number_ff     <= UDP_PROTOCOL;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_IP_VERSION_SIX:      ip_version_six_ff      <= csr_data[0];
            CSR_SOURCE_ADDRESS_HIGH: source_address_high_ff <= csr_data;
            CSR_SOURCE_ADDRESS_LOW:  source_address_low_ff  <= csr_data;
            CSR_DEST_ADDRESS_HIGH:   dest_address_high_ff   <= csr_data;
            CSR_DEST_ADDRESS_LOW:    dest_address_low_ff    <= csr_data;
            CSR_SOURCE_PORT:         source_port_ff         <= csr_data[15:0];
            CSR_DEST_PORT:           dest_port_ff           <= csr_data[15:0];
            CSR_PROTOCOL_NUMBER:     protocol_number_ff     <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // IPv4 uses only the low 32 address bits; IPv6 always carries protocol 17.
   always_comb begin
      if (ip_version_six_ff) begin
         src_high_used = source_address_high_ff;
         src_low_used  = source_address_low_ff;
         dst_high_used = dest_address_high_ff;
         dst_low_used  = dest_address_low_ff;
         protocol_used = UDP_PROTOCOL;
      end else begin
         src_high_used = '0;
         src_low_used  = {32'h0, source_address_low_ff[31:0]};
         dst_high_used = '0;
         dst_low_used  = {32'h0, dest_address_low_ff[31:0]};
         protocol_used = protocol_number_ff;
      end
      hdr_sum_in = HDR_SUM_W'(words_of_64(src_high_used))
                 + HDR_SUM_W'(words_of_64(src_low_used))
                 + HDR_SUM_W'(words_of_64(dst_high_used))
                 + HDR_SUM_W'(words_of_64(dst_low_used))
                 + HDR_SUM_W'(protocol_used)
                 + HDR_SUM_W'(source_port_ff)
                 + HDR_SUM_W'(dest_port_ff);
   end

   // The length-independent part of the pseudo header, registered in the cycle after the registers change.
   always_ff @(posedge clock) begin
      hdr_sum_ff <= hdr_sum_in;
   end

   assign hdr_sum = hdr_sum_ff;

endmodule

// ===== rtl/udpck_merge.sv =====
// Merge stage: adds the lane words into the running one's complement sum and
// holds a closed datagram's sum until the finish stage takes it. Depends on udpck_pkg.
`timescale 1ns / 1ps

module udpck_merge #(
   parameter int BYTES_PER_ITEM = udpck_pkg::DEFAULT_BYTES_PER_ITEM
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [BYTES_PER_ITEM-1:0][15:0]  lane_words,
   input  udpck_pkg::merge_ctrl_type        ctrl,
   input  logic [15:0]                      item_len,
   input  logic                             item_over,
   input  logic                             out_take,
   output logic                             advance,
   output udpck_pkg::stage_two_type         stage_two
);
   import udpck_pkg::*;

   localparam int LANE_SUM_W = 16 + $clog2(BYTES_PER_ITEM + 1);

   logic [15:0]           running_sum_ff;
   logic [15:0]           running_sum_in;
   stage_two_type         stage_two_ff;
   stage_two_type         stage_two_in;
   logic [LANE_SUM_W-1:0] lane_sum;
   logic [15:0]           merged;

   // Adder over the lanes plus the running sum, folded back to 16 bits.
   always_comb begin
      lane_sum = LANE_SUM_W'(running_sum_ff);
      for (int k = 0; k < BYTES_PER_ITEM; k++) begin
         lane_sum = lane_sum + LANE_SUM_W'(lane_words[k]);
      end
      merged = ones_fold_narrow(ones_fold_wide(32'(lane_sum)));
   end

   assign advance = !stage_two_ff.valid || out_take;

   // Next state: a last word closes the datagram and restarts the sum.
   always_comb begin
      running_sum_in = running_sum_ff;
      stage_two_in   = stage_two_ff;
      if (out_take) begin
         stage_two_in.valid = 1'b0;
      end
      if (ctrl.move) begin
         if (ctrl.last) begin
            running_sum_in     = '0;
            stage_two_in.valid = 1'b1;
            stage_two_in.sum   = merged;
            stage_two_in.len   = item_len;
            stage_two_in.over  = item_over;
         end else begin
            running_sum_in = merged;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff     <= '0;
         stage_two_ff.valid <= 1'b0;
      end else begin
         running_sum_ff     <= running_sum_in;
         stage_two_ff.valid <= stage_two_in.valid;
      end
      stage_two_ff.sum  <= stage_two_in.sum;
      stage_two_ff.len  <= stage_two_in.len;
      stage_two_ff.over <= stage_two_in.over;
   end

   assign stage_two = stage_two_ff;

endmodule

// ===== tb/tb_udp_pseudo_header_checksum_unit.sv =====
// Self-checking testbench for the UDP pseudo header checksum unit.
// Drives payload words and register writes, and checks every result against a local model.
// Depends on udpck_pkg and udp_pseudo_header_checksum_unit.
`timescale 1ns / 1ps

module tb_udp_pseudo_header_checksum_unit;
   import udpck_pkg::*;

   localparam int unsigned LANES        = 8;
   localparam int unsigned SETTLE_COUNT = 6;
   localparam int unsigned HOLD_CYCLES  = 400;

   typedef struct {
      req_word_type word;
      int unsigned  gap;
   } pending_word_type;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // Block ports.
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   udp_pseudo_header_checksum_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Shadow copy of the configuration registers.
   logic        cfg_ipv6      = 1'b0;
   logic [63:0] cfg_src_high  = '0;
   logic [63:0] cfg_src_low   = '0;
   logic [63:0] cfg_dst_high  = '0;
   logic [63:0] cfg_dst_low   = '0;
   logic [15:0] cfg_src_port  = '0;
   logic [15:0] cfg_dst_port  = '0;
   logic [7:0]  cfg_protocol  = UDP_PROTOCOL;

   // Model state: partial one's complement sum and payload byte count.
   logic [31:0]        partial_sum = '0;
   logic [TOTAL_W-1:0] payload_count = '0;

   pending_word_type pending_words[$];
   rsp_word_type     expected_checksums[$];

   int unsigned words_pushed     = 0;
   int unsigned words_accepted   = 0;
   int unsigned results_checked  = 0;
   int unsigned register_writes  = 0;
   int unsigned errors           = 0;

   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;
   int unsigned send_gap  = 0;
   int unsigned rx_wait   = 0;
   int unsigned rx_hold   = 0;

   // End-around fold of a 32-bit sum into 16 bits plus carry.
   function automatic logic [31:0] fold16(input logic [31:0] s);
      return {16'h0, s[15:0]} + {16'h0, s[31:16]};
   endfunction

   // Sum of the four 16-bit halfwords of a 64-bit register.
   function automatic logic [31:0] halfword_sum(input logic [63:0] v);
      return 32'(v[15:0]) + 32'(v[31:16]) + 32'(v[47:32]) + 32'(v[63:48]);
   endfunction

   // Adds one word to the running checksum; returns 1 with the result on a last word.
   function automatic bit checksum_word(input req_word_type w, output rsp_word_type r);
      int unsigned n;
      int unsigned k;
      logic [31:0] s;
      logic [7:0]  b;
      logic [15:0] len;
      logic        over;
      n = (w.valid_bytes > LANES) ? LANES : w.valid_bytes;
      s = partial_sum;
      r = '0;
      for (k = 0; k < n; k++) begin
         b = w.payload_bytes[63 - 8 * k -: 8];
         // Even positions land in the high half of a 16-bit word.
         s = s + (payload_count[0] ? {24'h0, b} : {16'h0, b, 8'h00});
         if (payload_count != TOTAL_MAX)
            payload_count = payload_count + 1'b1;
      end
      s = fold16(s);
      if (!w.last_item) begin
         partial_sum = s;
         return 1'b0;
      end
      over = payload_count > PAYLOAD_LIMIT;
      len  = over ? LENGTH_SATURATED : 16'(payload_count + 17'd8);
      if (cfg_ipv6) begin
         s = s + halfword_sum(cfg_src_high) + halfword_sum(cfg_src_low)
               + halfword_sum(cfg_dst_high) + halfword_sum(cfg_dst_low);
         s = s + 32'(len) + 32'(UDP_PROTOCOL);
         s = s + 32'(cfg_src_port) + 32'(cfg_dst_port) + 32'(len);
      end else begin
         s = s + halfword_sum({32'h0, cfg_src_low[31:0]})
               + halfword_sum({32'h0, cfg_dst_low[31:0]});
         s = s + 32'(cfg_protocol);
         s = s + 32'(len) + 32'(cfg_src_port) + 32'(cfg_dst_port) + 32'(len);
      end
      s = fold16(fold16(s));
      r.checksum_value  = ~s[15:0];
      r.datagram_length = len;
      r.length_overflow = over;
      partial_sum   = '0;
      payload_count = '0;
      return 1'b1;
   endfunction

   // Sample both channels at the rising edge, predict and compare.
   always @(posedge clock) begin : monitor
      rsp_word_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
         if (req_valid && !req_stall) begin
            words_accepted++;
            if (checksum_word(req_word, want))
               expected_checksums.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_checksums.size() == 0) begin
               errors++;
               $display("%0t: unexpected result word, expected none, got %h", $time, rsp_word);
            end else begin
               want = expected_checksums.pop_front();
               if (rsp_word.checksum_value !== want.checksum_value) begin
                  errors++;
                  $display("%0t: checksum_value expected %h, got %h",
                           $time, want.checksum_value, rsp_word.checksum_value);
               end
               if (rsp_word.datagram_length !== want.datagram_length) begin
                  errors++;
                  $display("%0t: datagram_length expected %h, got %h",
                           $time, want.datagram_length, rsp_word.datagram_length);
               end
               if (rsp_word.length_overflow !== want.length_overflow) begin
                  errors++;
                  $display("%0t: length_overflow expected %b, got %b",
                           $time, want.length_overflow, rsp_word.length_overflow);
               end
            end
         end
      end
   end

   // Sender: presents queued words at the falling edge, with a random gap, possibly none, after each word.
   always @(negedge clock) begin : sender
      pending_word_type next_word;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (req_valid && !req_taken) begin
         // Word still waiting for acceptance; hold it.
      end else if (send_gap != 0) begin
         req_valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else if (pending_words.size() != 0) begin
         next_word = pending_words.pop_front();
         req_word  <= next_word.word;
         req_valid <= 1'b1;
         send_gap  <= next_word.gap;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: random stall before each result, stretches without stalls, and two long holds.
   always @(negedge clock) begin : receiver
      int unsigned n;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rx_hold != 0) begin
         rsp_stall <= 1'b1;
         rx_hold   <= rx_hold - 1;
      end else if (rsp_taken && (results_checked == 60 || results_checked == 250)) begin
         rsp_stall <= 1'b1;
         rx_hold   <= HOLD_CYCLES;
      end else if (rsp_taken) begin
         n = ((results_checked / 50) % 3 == 0) ? 0 : $urandom_range(0, 11);
         rsp_stall <= (n != 0);
         rx_wait   <= (n != 0) ? n - 1 : 0;
      end else if (rx_wait != 0) begin
         rsp_stall <= 1'b1;
         rx_wait   <= rx_wait - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [63:0] rand_payload();
      return {$urandom(), $urandom()};
   endfunction

   // Register values lean toward the extremes.
   function automatic logic [63:0] rand_reg_value();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic push_word(input logic [63:0] payload, input int unsigned count,
                            input bit last, input int unsigned gap_max);
      pending_word_type w;
      w.word.payload_bytes = payload;
      w.word.valid_bytes   = 4'(count);
      w.word.last_item     = last;
      w.gap                = $urandom_range(0, gap_max);
      pending_words.push_back(w);
      words_pushed++;
   endtask

   // Wait until every word is taken and every result has come back, then let the pipe drain.
   task automatic settle();
      while (words_accepted != words_pushed || expected_checksums.size() != 0)
         @(negedge clock);
      repeat (SETTLE_COUNT) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      register_writes++;
      case (idx)
         CSR_IP_VERSION_SIX:      cfg_ipv6     = value[0];
         CSR_SOURCE_ADDRESS_HIGH: cfg_src_high = value;
         CSR_SOURCE_ADDRESS_LOW:  cfg_src_low  = value;
         CSR_DEST_ADDRESS_HIGH:   cfg_dst_high = value;
         CSR_DEST_ADDRESS_LOW:    cfg_dst_low  = value;
         CSR_SOURCE_PORT:         cfg_src_port = value[15:0];
         CSR_DEST_PORT:           cfg_dst_port = value[15:0];
         CSR_PROTOCOL_NUMBER:     cfg_protocol = value[7:0];
         default: ;
      endcase
   endtask

   // Drains the block, then rewrites all eight registers.
   task automatic load_config(input logic ipv6, input logic [63:0] src_high,
                              input logic [63:0] src_low, input logic [63:0] dst_high,
                              input logic [63:0] dst_low, input logic [63:0] src_port,
                              input logic [63:0] dst_port, input logic [63:0] protocol);
      settle();
      write_reg(CSR_IP_VERSION_SIX, {63'h0, ipv6});
      write_reg(CSR_SOURCE_ADDRESS_HIGH, src_high);
      write_reg(CSR_SOURCE_ADDRESS_LOW, src_low);
      write_reg(CSR_DEST_ADDRESS_HIGH, dst_high);
      write_reg(CSR_DEST_ADDRESS_LOW, dst_low);
      write_reg(CSR_SOURCE_PORT, src_port);
      write_reg(CSR_DEST_PORT, dst_port);
      write_reg(CSR_PROTOCOL_NUMBER, protocol);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_random_config();
      load_config(1'($urandom_range(0, 1)), rand_reg_value(), rand_reg_value(),
                  rand_reg_value(), rand_reg_value(), rand_reg_value(),
                  rand_reg_value(), rand_reg_value());
   endtask

   // Mostly well-formed datagrams with random content, some malformed words in between.
   task automatic random_traffic(input int unsigned n_words, input int unsigned gap_max);
      int unsigned done_words;
      int unsigned pick;
      int unsigned span;
      int unsigned k;
      done_words = 0;
      while (done_words < n_words) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            case ($urandom_range(0, 2))
               0: push_word(rand_payload(), 0, 1'($urandom_range(0, 1)), gap_max);
               1: push_word(rand_payload(), $urandom_range(9, 15), 1'($urandom_range(0, 1)),
                            gap_max);
               default: push_word(rand_payload(), $urandom_range(1, 7), 1'b0, gap_max);
            endcase
            done_words++;
         end else begin
            span = (pick == 1) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            for (k = 1; k < span; k++)
               push_word(rand_payload(), LANES, 1'b0, gap_max);
            push_word(rand_payload(), $urandom_range(1, 8), 1'b1, gap_max);
            done_words += span;
         end
      end
      // Close any datagram a malformed word left open.
      push_word(rand_payload(), $urandom_range(1, 8), 1'b1, gap_max);
   endtask

   // Stimulus sequence.
   initial begin : stimulus
      int unsigned phase;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: field extremes, empty and oversized counts, odd splits.
      push_word('0, 8, 1'b1, 3);
      push_word('1, 8, 1'b1, 3);
      push_word(rand_payload(), 0, 1'b1, 3);
      push_word('1, 15, 1'b1, 3);
      push_word(rand_payload(), 9, 1'b0, 3);
      push_word(rand_payload(), 1, 1'b1, 3);
      push_word(rand_payload(), 3, 1'b0, 3);
      push_word(rand_payload(), 0, 1'b0, 3);
      push_word(rand_payload(), 5, 1'b0, 3);
      push_word(rand_payload(), 7, 1'b1, 3);
      push_word(rand_payload(), 1, 1'b1, 3);

      // All registers zero: this payload makes the checksum come out as zero.
      load_config(1'b0, '0, '0, '0, '0, '0, '0, '0);
      push_word(64'hFFEB_0000_0000_0000, 2, 1'b1, 3);
      push_word('0, 0, 1'b1, 3);

      // All registers at their maximum, IPv4 and then IPv6.
      load_config(1'b0, '1, '1, '1, '1, '1, '1, '1);
      push_word('1, 8, 1'b0, 3);
      push_word('1, 8, 1'b1, 3);
      push_word(rand_payload(), 15, 1'b1, 3);
      load_config(1'b1, '1, '1, '1, '1, '1, '1, '1);
      push_word(rand_payload(), 8, 1'b1, 3);
      push_word(rand_payload(), 3, 1'b1, 3);
      push_word('0, 0, 1'b1, 3);

      // Random datagrams under a fresh configuration per phase.
      for (phase = 0; phase < 6; phase++) begin
         load_random_config();
         random_traffic(290, (phase % 3 == 0) ? 0 : 11);
      end

      settle();
      repeat (SETTLE_COUNT) @(posedge clock);
      $display("Covered %0d words, %0d checksum results and %0d register writes.",
               words_accepted, results_checked, register_writes);
      $display("IPv4 and IPv6 headers, odd splits, empty and oversized words included.");
      if (errors == 0 && expected_checksums.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #(25_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule
